>>> sv/imapr_pkg.sv
// ----------------------------------------------------------------------------
// imapr_pkg
// Shared types, reply microprogram and keyword tables of the IMAP command
// line responder.
// ----------------------------------------------------------------------------
package imapr_pkg;

    // Default tag capacity in bytes
    localparam int TAG_MAX_DEF = 32;

    // One received beat
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       connect;
    } t_in_item;

    // One reply beat
    typedef struct packed {
        logic [7:0] reply_byte;
        logic       last_of_reply;
        logic       close_after;
        logic       protocol_error;
    } t_out_item;

    // Command recognized on a line
    typedef enum logic [1:0] {
        REQ_NONE    = 2'd0,
        REQ_UNKNOWN = 2'd1,
        REQ_CAPA    = 2'd2,
        REQ_QUIT    = 2'd3
    } t_req;

    // Micro-operations of the reply sequencer
    typedef enum logic {
        UOP_CHAR = 1'b0,  // emit the constant byte of this word
        UOP_TAG  = 1'b1   // emit tag bytes, then jump to the dispatch address
    } t_uop;

    typedef struct packed {
        t_uop       op;
        logic [7:0] ch;
        logic       last;
        logic       close;
    } t_uword;

    // Microprogram layout: one tag-echo word, then the reply texts
    localparam int ROM_DEPTH = 84;
    localparam int UPC_W     = $clog2(ROM_DEPTH);

    localparam int A_TAG     = 0;
    localparam int A_GREET   = 1;
    localparam int A_NOTAG   = 7;
    localparam int A_OK      = 26;
    localparam int A_BYE     = 31;
    localparam int A_UNK     = 40;
    localparam int A_NOCMD   = 62;

    localparam int END_GREET = 6;
    localparam int END_NOTAG = 25;
    localparam int END_OK    = 30;
    localparam int END_BYE   = 39;
    localparam int END_UNK   = 61;
    localparam int END_NOCMD = 83;

    localparam logic [15:0] CRLF = 16'h0D0A;
    localparam logic [7:0]  CH_CR = 8'h0D;

    // Text bytes, address 0 first (most significant byte)
    localparam logic [8*ROM_DEPTH-1:0] TEXT = {
        8'h00,
        "* OK", CRLF,
        "* ERR MISSING TAG", CRLF,
        " OK", CRLF,
        " OK BYE", CRLF,
        " ERR COMMAND UNKNOWN", CRLF,
        " ERR MISSING COMMAND", CRLF
    };

    localparam logic [79:0] KW_CAP    = "CAPABILITY";
    localparam logic [47:0] KW_LOGOUT = "LOGOUT";

    // Fetch one control word of the reply microprogram
    function automatic t_uword uword(input logic [UPC_W-1:0] a);
        t_uword w;
        int     sel;
        sel     = ROM_DEPTH - 1 - int'(a);
        w.op    = (a == UPC_W'(A_TAG)) ? UOP_TAG : UOP_CHAR;
        w.ch    = TEXT[8*sel +: 8];
        w.last  = (a == UPC_W'(END_GREET)) || (a == UPC_W'(END_NOTAG)) ||
                  (a == UPC_W'(END_OK))    || (a == UPC_W'(END_BYE))   ||
                  (a == UPC_W'(END_UNK))   || (a == UPC_W'(END_NOCMD));
        w.close = (a == UPC_W'(END_BYE));
        return w;
    endfunction

    // Keyword letter matches at a position
    function automatic logic cap_hit(input logic [3:0] p, input logic [7:0] c);
        int sel;
        sel = (p < 4'd10) ? (9 - int'(p)) : 0;
        return (p < 4'd10) && (c == KW_CAP[8*sel +: 8]);
    endfunction

    function automatic logic logout_hit(input logic [3:0] p, input logic [7:0] c);
        int sel;
        sel = (p < 4'd6) ? (5 - int'(p)) : 0;
        return (p < 4'd6) && (c == KW_LOGOUT[8*sel +: 8]);
    endfunction

endpackage

>>> sv/imap_command_line_responder_core.sv
// ----------------------------------------------------------------------------
// imap_command_line_responder_core
// Parses IMAP command lines byte by byte and plays back replies from a
// microcoded reply sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one received
//   byte per beat, or a connect beat that restarts the parser and asks for
//   the greeting. Output channel (o_out_valid / i_out_stall / o_out_data)
//   carries one reply character per beat, flagged on the last one.
//   Ordinary bytes are taken one per cycle while no reply is pending, and
//   produce no output. A CR or a connect beat starts the reply sequencer:
//   one reply byte per cycle while the output is not stalled. A reply
//   (tag length plus text, at most TAG_MAX + 22 bytes) holds o_in_stall
//   until its last byte is registered. The rate is set by the sequencer,
//   which walks the tag store and the text table one word per cycle. The
//   next byte is taken while the last reply byte still sits in the output register.
//   A stall on the output freezes the output register and the sequencer;
//   the input stays stalled until the last reply byte has been registered.
//   Reset (synchronous, active low) returns the parser to expecting a tag
//   with no reply pending. The tag store is not cleared.
// ----------------------------------------------------------------------------
module imap_command_line_responder_core #(
    parameter int TAG_MAX = imapr_pkg::TAG_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  imapr_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output imapr_pkg::t_out_item o_out_data
);

    localparam int IDX_W = (TAG_MAX > 1) ? $clog2(TAG_MAX) : 1;
    localparam int LEN_W = $clog2(TAG_MAX + 1);
    localparam int UPC_W = imapr_pkg::UPC_W;

    typedef enum logic [2:0] {
        PH_EXPECT_TAG = 3'd0,
        PH_IN_TAG     = 3'd1,
        PH_EXPECT_KEY = 3'd2,
        PH_IN_KEY     = 3'd3,
        PH_IGNORE     = 3'd4,
        PH_SKIP_ERR   = 3'd5
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [LEN_W-1:0]     r_tag_len, n_tag_len;
    logic [3:0]           r_kw_pos, n_kw_pos;
    logic [1:0]           r_kw_cand, n_kw_cand;
    imapr_pkg::t_req      r_cmd, n_cmd;

    logic                 r_busy, n_busy;
    logic [UPC_W-1:0]     r_upc, n_upc;
    logic [UPC_W-1:0]     r_cont, n_cont;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_perr, n_perr;

    logic                 r_out_valid;
    imapr_pkg::t_out_item r_out;

    logic [7:0]           r_mem [TAG_MAX];
    logic [7:0]           r_tag_q;

    logic                 in_acc;
    logic                 adv;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wa;
    logic [7:0]           c;
    logic                 is_sp, is_al, is_an;
    logic [3:0]           feed_pos;
    logic [1:0]           feed_cand;
    imapr_pkg::t_req      fin_cmd;
    imapr_pkg::t_req      eol_cmd;
    logic                 has_tag;
    imapr_pkg::t_uword    w;

    assign in_acc = i_in_valid && !o_in_stall;
    assign adv    = r_busy && (!r_out_valid || !i_out_stall);
    assign w      = imapr_pkg::uword(r_upc);

    // Character classes
    assign c     = i_in_data.rx_byte;
    assign is_sp = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
                   (c == 8'h0B) || (c == 8'h0C);
    assign is_al = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    assign is_an = is_al || ((c >= 8'h30) && (c <= 8'h39));

    // Keyword evaluation on the current state
    always_comb begin
        if (r_kw_cand[0] && (r_kw_pos == 4'd10)) begin
            fin_cmd = imapr_pkg::REQ_CAPA;
        end else if (r_kw_cand[1] && (r_kw_pos == 4'd6)) begin
            fin_cmd = imapr_pkg::REQ_QUIT;
        end else begin
            fin_cmd = imapr_pkg::REQ_UNKNOWN;
        end
        eol_cmd = (r_phase == PH_IN_KEY) ? fin_cmd : r_cmd;
        has_tag = (r_phase == PH_IN_TAG) || (r_phase == PH_EXPECT_KEY) ||
                  (r_phase == PH_IN_KEY) || (r_phase == PH_IGNORE);
        feed_pos  = (r_phase == PH_IN_KEY) ? r_kw_pos : 4'd0;
        feed_cand = (r_phase == PH_IN_KEY) ? r_kw_cand : 2'b11;
    end

    // Parser next state
    always_comb begin
        n_phase   = r_phase;
        n_tag_len = r_tag_len;
        n_kw_pos  = r_kw_pos;
        n_kw_cand = r_kw_cand;
        n_cmd     = r_cmd;
        mem_we    = 1'b0;
        mem_wa    = r_tag_len[IDX_W-1:0];
        if (in_acc) begin
            if (i_in_data.connect || (c == imapr_pkg::CH_CR)) begin
                // Line end or new connection: start a fresh line, keep the
                // tag length for the echo (the next tag restarts it)
                n_phase   = PH_EXPECT_TAG;
                n_kw_pos  = 4'd0;
                n_kw_cand = 2'b11;
                n_cmd     = imapr_pkg::REQ_NONE;
            end else begin
                case (r_phase)
                    PH_EXPECT_TAG: begin
                        if (is_an) begin
                            n_phase   = PH_IN_TAG;
                            mem_we    = 1'b1;
                            mem_wa    = '0;
                            n_tag_len = LEN_W'(1);
                        end else if (!is_sp) begin
                            n_phase = PH_SKIP_ERR;
                        end
                    end
                    PH_IN_TAG, PH_EXPECT_KEY: begin
                        if ((r_phase == PH_IN_TAG) && is_an) begin
                            // Keep tag bytes up to the store size
                            if (r_tag_len < LEN_W'(TAG_MAX)) begin
                                mem_we    = 1'b1;
                                n_tag_len = r_tag_len + LEN_W'(1);
                            end
                        end else if (is_sp) begin
                            n_phase = PH_EXPECT_KEY;
                        end else if (is_al) begin
                            n_phase   = PH_IN_KEY;
                            n_kw_cand = feed_cand & {imapr_pkg::logout_hit(feed_pos, c),
                                                     imapr_pkg::cap_hit(feed_pos, c)};
                            n_kw_pos  = 4'd1;
                        end else begin
                            n_phase = PH_IGNORE;
                        end
                    end
                    PH_IN_KEY: begin
                        if (is_al) begin
                            n_kw_cand = feed_cand & {imapr_pkg::logout_hit(feed_pos, c),
                                                     imapr_pkg::cap_hit(feed_pos, c)};
                            if (r_kw_pos != 4'd15) begin
                                n_kw_pos = r_kw_pos + 4'd1;
                            end
                        end else begin
                            n_cmd   = fin_cmd;
                            n_phase = PH_IGNORE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // Reply sequencer next state
    always_comb begin
        n_busy = r_busy;
        n_upc  = r_upc;
        n_cont = r_cont;
        n_idx  = r_idx;
        n_perr = r_perr;
        if (in_acc && (i_in_data.connect || (c == imapr_pkg::CH_CR))) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_perr = !i_in_data.connect && (r_phase == PH_SKIP_ERR);
            if (i_in_data.connect) begin
                n_upc = UPC_W'(imapr_pkg::A_GREET);
            end else if (has_tag) begin
                n_upc = UPC_W'(imapr_pkg::A_TAG);
            end else begin
                n_upc = UPC_W'(imapr_pkg::A_NOTAG);
            end
            case (eol_cmd)
                imapr_pkg::REQ_CAPA:    n_cont = UPC_W'(imapr_pkg::A_OK);
                imapr_pkg::REQ_QUIT:    n_cont = UPC_W'(imapr_pkg::A_BYE);
                imapr_pkg::REQ_UNKNOWN: n_cont = UPC_W'(imapr_pkg::A_UNK);
                default:                n_cont = UPC_W'(imapr_pkg::A_NOCMD);
            endcase
        end else if (adv) begin
            if (w.op == imapr_pkg::UOP_TAG) begin
                // Loop over the tag, then jump to the chosen reply text
                if ((LEN_W'(r_idx) + LEN_W'(1)) == r_tag_len) begin
                    n_upc = r_cont;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end else if (w.last) begin
                n_busy = 1'b0;
            end else begin
                n_upc = r_upc + UPC_W'(1);
            end
        end
    end

    // Tag store: write one byte, read the next tag byte to emit
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= c;
        end
        r_tag_q <= r_mem[n_idx];
    end

    // Hold state and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_EXPECT_TAG;
            r_tag_len   <= '0;
            r_kw_pos    <= 4'd0;
            r_kw_cand   <= 2'b11;
            r_cmd       <= imapr_pkg::REQ_NONE;
            r_busy      <= 1'b0;
            r_upc       <= '0;
            r_cont      <= '0;
            r_idx       <= '0;
            r_perr      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_tag_len <= n_tag_len;
            r_kw_pos  <= n_kw_pos;
            r_kw_cand <= n_kw_cand;
            r_cmd     <= n_cmd;
            r_busy    <= n_busy;
            r_upc     <= n_upc;
            r_cont    <= n_cont;
            r_idx     <= n_idx;
            r_perr    <= n_perr;
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (adv) begin
            r_out.reply_byte     <= (w.op == imapr_pkg::UOP_TAG) ? r_tag_q : w.ch;
            r_out.last_of_reply  <= w.last;
            r_out.close_after    <= w.close;
            r_out.protocol_error <= r_perr;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> sv/imapr_checker.sv
// ----------------------------------------------------------------------------
// imapr_checker
// Port-level checks of the IMAP command line responder, bound to the core.
// ----------------------------------------------------------------------------
module imapr_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input imapr_pkg::t_in_item  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input imapr_pkg::t_out_item o_out_data
);

    // Hold a stalled reply beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled reply beat changed");

    // Close only on the final beat of a reply
    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.close_after |-> o_out_data.last_of_reply)
        else $error("close flag off the last reply beat");

    // A connect beat starts a reply and holds off input
    a_connect_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && !o_in_stall && i_in_data.connect |=> o_in_stall)
        else $error("connect did not start a reply");

    // An ordinary byte never starts a reply
    a_plain_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && !o_in_stall && !i_in_data.connect &&
        (i_in_data.rx_byte != imapr_pkg::CH_CR) |=> !o_in_stall)
        else $error("ordinary byte stalled the input");

endmodule

bind imap_command_line_responder_core imapr_checker u_imapr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
